@@ hdl/calendar_date_sequencer_assert.svh @@
// Assertion macros for the calendar date sequencer.
// Used by the top level; expects clock and reset in the including scope.
`ifndef CALENDAR_DATE_SEQUENCER_ASSERT_SVH
`define CALENDAR_DATE_SEQUENCER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CDS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("calendar_date_sequencer: same-cycle check failed");
`define CDS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("calendar_date_sequencer: next-cycle check failed");
`else
`define CDS_ASSERT_NOW(label, ante, cons)
`define CDS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ hdl/cds_pkg.sv @@
// Shared types, constants and calendar functions for the date sequencer.
// No dependencies; used by cds_weekday_walk and calendar_date_sequencer.
`timescale 1ns / 1ps
package cds_pkg;

   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;
   localparam int WDAY_W  = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int ADD_W   = 6;

   localparam logic [YEAR_W-1:0]  EPOCH_YEAR = 14'd1923;
   localparam logic [YEAR_W-1:0]  YEAR_MAX   = '1;
   localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_APR  = 4'd4;
   localparam logic [MONTH_W-1:0] MONTH_JUN  = 4'd6;
   localparam logic [MONTH_W-1:0] MONTH_SEP  = 4'd9;
   localparam logic [MONTH_W-1:0] MONTH_NOV  = 4'd11;
   localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
   localparam logic [DAY_W-1:0]   DAY_FIRST  = 5'd1;
   localparam logic [DAY_W-1:0]   LEN_31     = 5'd31;
   localparam logic [DAY_W-1:0]   LEN_30     = 5'd30;
   localparam logic [DAY_W-1:0]   LEN_29     = 5'd29;
   localparam logic [DAY_W-1:0]   LEN_28     = 5'd28;
   localparam logic [WDAY_W-1:0]  WDAY_MONDAY   = 3'd1;
   localparam logic [WDAY_W-1:0]  WDAY_SATURDAY = 3'd6;
   localparam logic [WDAY_W-1:0]  WDAY_SUNDAY   = 3'd0;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FIRST_DAY   = 3'd0,
      CSR_FIRST_MONTH = 3'd1,
      CSR_FIRST_YEAR  = 3'd2,
      CSR_FINAL_DAY   = 3'd3,
      CSR_FINAL_MONTH = 3'd4,
      CSR_FINAL_YEAR  = 3'd5
   } csr_index_type;

   // year, month, day packed in that order so a plain compare orders dates
   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
   } date_type;

   typedef struct packed {
      logic start;
      logic ack;
   } walk_ctrl_type;

   typedef struct packed {
      logic              done;
      logic [WDAY_W-1:0] weekday;
   } walk_stat_type;

   // y mod 25 folds as 3*y[13:7] + y[6:0]; divisible by 400 is by 25 and 16
   function automatic logic is_leap(input logic [YEAR_W-1:0] y);
      logic [8:0] fold;
      logic       div25;
      fold  = ({2'b00, y[13:7]} << 1) + {2'b00, y[13:7]} + {2'b00, y[6:0]};
      div25 = 1'b0;
      for (int k = 0; k <= 20; k++) begin
         if (fold == 9'(25 * k)) begin
            div25 = 1'b1;
         end
      end
      return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic [YEAR_W-1:0] y);
      logic [DAY_W-1:0] len;
      if (m inside {MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV}) begin
         len = LEN_30;
      end else if (m == MONTH_FEB) begin
         len = is_leap(y) ? LEN_29 : LEN_28;
      end else begin
         len = LEN_31;
      end
      return len;
   endfunction

   // 8 is 1 mod 7: fold the octal digits, then two conditional subtracts
   function automatic logic [WDAY_W-1:0] mod7(input logic [ADD_W-1:0] v);
      logic [3:0] t;
      t = {1'b0, v[5:3]} + {1'b0, v[2:0]};
      if (t >= 4'd7) begin
         t = t - 4'd7;
      end
      if (t >= 4'd7) begin
         t = t - 4'd7;
      end
      return t[2:0];
   endfunction

endpackage

@@ hdl/calendar_date_sequencer.sv @@
// An advance transfer gives its result in the output register in the next cycle. A restart
// walks the years since 1923, then the months, then the day through the shared mod-7
// accumulator in cds_weekday_walk, and loads its result when the walk is done.
// Throughput: one advance per cycle unless rsp_stall holds it; a walk holds req_stall high.
// Reset (synchronous): both dates 1/1/1923, current date 1/1/1923 Monday, run idle.
`timescale 1ns / 1ps
`include "calendar_date_sequencer_assert.svh"
module calendar_date_sequencer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_restart,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_valid_res,
   output logic [cds_pkg::DAY_W-1:0]          rsp_date_day,
   output logic [cds_pkg::MONTH_W-1:0]        rsp_date_month,
   output logic [cds_pkg::YEAR_W-1:0]         rsp_date_year,
   output logic [cds_pkg::WDAY_W-1:0]         rsp_weekday,
   output logic                               rsp_last,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [cds_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [cds_pkg::YEAR_W-1:0]         csr_wdata
);

   typedef enum logic {
      ST_READY,
      ST_WALK
   } seq_state_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_RUN,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic                          give;
      cds_pkg::date_type             date;
      logic [cds_pkg::WDAY_W-1:0]    weekday;
      logic                          last;
   } result_type;

   seq_state_type                 state_ff, state_in;
   phase_type                     phase_ff, phase_in;
   cds_pkg::date_type             first_ff, final_ff;
   cds_pkg::date_type             cur_ff, cur_in;
   logic [cds_pkg::WDAY_W-1:0]    wday_ff, wday_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   result_type                    rsp_ff, res;
   logic                          slot_free, accept, load, wrapped;
   cds_pkg::date_type             next_date;
   logic [cds_pkg::WDAY_W-1:0]    next_wday;
   cds_pkg::walk_ctrl_type        walk_ctrl;
   cds_pkg::walk_stat_type        walk_stat;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_READY) && slot_free);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign walk_ctrl.start = accept && req_restart;
   assign walk_ctrl.ack   = (state_ff == ST_WALK) && walk_stat.done && slot_free;
   assign load            = (accept && !req_restart) || walk_ctrl.ack;

   cds_weekday_walk u_walk (
      .clock (clock),
      .reset (reset),
      .ctrl  (walk_ctrl),
      .date  (cur_ff),
      .stat  (walk_stat)
   );

   // one day forward
   always_comb begin
      next_date = cur_ff;
      wrapped   = 1'b0;
      if (cur_ff.day >= cds_pkg::month_len(cur_ff.month, cur_ff.year)) begin
         next_date.day = cds_pkg::DAY_FIRST;
         if (cur_ff.month >= cds_pkg::MONTH_DEC) begin
            next_date.month = cds_pkg::MONTH_JAN;
            next_date.year  = cur_ff.year + 1'b1;
            wrapped         = (cur_ff.year == cds_pkg::YEAR_MAX);
         end else begin
            next_date.month = cur_ff.month + 1'b1;
         end
      end else begin
         next_date.day = cur_ff.day + 1'b1;
      end
      next_wday = (wday_ff == cds_pkg::WDAY_SATURDAY) ? cds_pkg::WDAY_SUNDAY
                                                       : wday_ff + 1'b1;
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      cur_in   = cur_ff;
      wday_in  = wday_ff;
      res      = '0;
      if (accept && req_restart) begin
         state_in = ST_WALK;
         cur_in   = first_ff;
      end
      if (walk_ctrl.ack) begin
         state_in = ST_READY;
         wday_in  = walk_stat.weekday;
         if (final_ff < cur_ff) begin
            phase_in = PH_DONE;
         end else begin
            phase_in    = PH_RUN;
            res.give    = 1'b1;
            res.date    = cur_ff;
            res.weekday = walk_stat.weekday;
            res.last    = (cur_ff == final_ff);
         end
      end
      if (accept && !req_restart && (phase_ff == PH_RUN)) begin
         if (cur_ff == final_ff) begin
            phase_in = PH_DONE;
         end else begin
            cur_in  = next_date;
            wday_in = next_wday;
            if (wrapped || (next_date > final_ff)) begin
               phase_in = PH_DONE;
            end else begin
               res.give    = 1'b1;
               res.date    = next_date;
               res.weekday = next_wday;
               res.last    = (next_date == final_ff);
            end
         end
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_READY;
         phase_ff       <= PH_IDLE;
         cur_ff.day     <= cds_pkg::DAY_FIRST;
         cur_ff.month   <= cds_pkg::MONTH_JAN;
         cur_ff.year    <= cds_pkg::EPOCH_YEAR;
         wday_ff        <= cds_pkg::WDAY_MONDAY;
         first_ff.day   <= cds_pkg::DAY_FIRST;
         first_ff.month <= cds_pkg::MONTH_JAN;
         first_ff.year  <= cds_pkg::EPOCH_YEAR;
         final_ff.day   <= cds_pkg::DAY_FIRST;
         final_ff.month <= cds_pkg::MONTH_JAN;
         final_ff.year  <= cds_pkg::EPOCH_YEAR;
         rsp_valid_ff   <= 1'b0;
         rsp_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         cur_ff       <= cur_in;
         wday_ff      <= wday_in;
         rsp_valid_ff <= rsp_valid_in;
         if (load) begin
            rsp_ff <= res;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               cds_pkg::CSR_FIRST_DAY:   first_ff.day   <= csr_wdata[cds_pkg::DAY_W-1:0];
               cds_pkg::CSR_FIRST_MONTH: first_ff.month <= csr_wdata[cds_pkg::MONTH_W-1:0];
               cds_pkg::CSR_FIRST_YEAR:  first_ff.year  <= csr_wdata;
               cds_pkg::CSR_FINAL_DAY:   final_ff.day   <= csr_wdata[cds_pkg::DAY_W-1:0];
               cds_pkg::CSR_FINAL_MONTH: final_ff.month <= csr_wdata[cds_pkg::MONTH_W-1:0];
               cds_pkg::CSR_FINAL_YEAR:  final_ff.year  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_valid_res  = rsp_ff.give;
   assign rsp_date_day   = rsp_ff.date.day;
   assign rsp_date_month = rsp_ff.date.month;
   assign rsp_date_year  = rsp_ff.date.year;
   assign rsp_weekday    = rsp_ff.weekday;
   assign rsp_last       = rsp_ff.last;

   `CDS_ASSERT_NOW(a_empty_result_zero, rsp_valid && !rsp_valid_res, rsp_ff == '0)
   `CDS_ASSERT_NOW(a_weekday_range, rsp_valid && rsp_valid_res, rsp_weekday <= cds_pkg::WDAY_SATURDAY)
   `CDS_ASSERT_NEXT(a_stopped_run_silent, accept && !req_restart && (phase_ff != PH_RUN), rsp_valid && !rsp_valid_res)

endmodule

@@ hdl/cds_weekday_walk.sv @@
// Weekday of a date: steps years since the epoch, then months, then the day,
// through one shared mod-7 accumulator. Depends on cds_pkg.
`timescale 1ns / 1ps
module cds_weekday_walk (
   input  logic                    clock,
   input  logic                    reset,
   input  cds_pkg::walk_ctrl_type  ctrl,
   input  cds_pkg::date_type       date,
   output cds_pkg::walk_stat_type  stat
);

   typedef enum logic [2:0] {
      W_IDLE,
      W_YEARS,
      W_MONTHS,
      W_DAY,
      W_DONE
   } walk_state_type;

   walk_state_type                      state_ff, state_in;
   logic [cds_pkg::WDAY_W-1:0]          acc_ff, acc_in;
   logic [cds_pkg::YEAR_W-1:0]          year_ff, year_in;
   logic [cds_pkg::MONTH_W-1:0]         mon_ff, mon_in;
   logic [cds_pkg::ADD_W-1:0]           addend;
   logic [cds_pkg::WDAY_W-1:0]          acc_sum;

   // shared unit: acc + addend mod 7
   always_comb begin
      case (state_ff)
         W_YEARS:  addend = cds_pkg::is_leap(year_ff) ? 6'd2 : 6'd1;
         W_MONTHS: addend = {1'b0, cds_pkg::month_len(mon_ff, date.year)};
         W_DAY:    addend = {1'b0, date.day};
         default:  addend = '0;
      endcase
      acc_sum = cds_pkg::mod7({3'b000, acc_ff} + addend);
   end

   always_comb begin
      state_in = state_ff;
      acc_in   = acc_ff;
      year_in  = year_ff;
      mon_in   = mon_ff;
      case (state_ff)
         W_IDLE: begin
            if (ctrl.start) begin
               acc_in   = '0;
               year_in  = cds_pkg::EPOCH_YEAR;
               mon_in   = cds_pkg::MONTH_JAN;
               state_in = W_YEARS;
            end
         end
         W_YEARS: begin
            if (year_ff < date.year) begin
               acc_in  = acc_sum;
               year_in = year_ff + 1'b1;
            end else begin
               state_in = W_MONTHS;
            end
         end
         W_MONTHS: begin
            if (mon_ff < date.month) begin
               acc_in = acc_sum;
               mon_in = mon_ff + 1'b1;
            end else begin
               state_in = W_DAY;
            end
         end
         W_DAY: begin
            acc_in   = acc_sum;
            state_in = W_DONE;
         end
         W_DONE: begin
            if (ctrl.ack) begin
               state_in = W_IDLE;
            end
         end
         default: state_in = W_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= W_IDLE;
         acc_ff   <= '0;
         year_ff  <= cds_pkg::EPOCH_YEAR;
         mon_ff   <= cds_pkg::MONTH_JAN;
      end else begin
         state_ff <= state_in;
         acc_ff   <= acc_in;
         year_ff  <= year_in;
         mon_ff   <= mon_in;
      end
   end

   assign stat.done    = (state_ff == W_DONE);
   assign stat.weekday = acc_ff;

endmodule

@@ tb/date_walk_checker.sv @@
// Checker for the calendar date sequencer: watches request, result and register transfers,
// predicts each result with its own calendar arithmetic and compares field by field.
// Depends on cds_pkg for field widths, the date type and register indexes.
`timescale 1ns / 1ps
module date_walk_checker
   import cds_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic                   req_restart,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic                   rsp_valid_res,
   input  logic [DAY_W-1:0]       rsp_date_day,
   input  logic [MONTH_W-1:0]     rsp_date_month,
   input  logic [YEAR_W-1:0]      rsp_date_year,
   input  logic [WDAY_W-1:0]      rsp_weekday,
   input  logic                   rsp_last,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [YEAR_W-1:0]      csr_wdata,
   output int                     mismatches,
   output int                     outstanding,
   output int                     checked
);

   typedef enum logic [1:0] {WALK_IDLE, WALK_RUN, WALK_DONE} walk_phase_type;

   typedef struct packed {
      logic               valid_res;
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
      logic [WDAY_W-1:0]  weekday;
      logic               last;
   } date_result_type;

   date_type          start_date;
   date_type          stop_date;
   date_type          cur_date;
   logic [WDAY_W-1:0] cur_wday;
   walk_phase_type    phase;
   date_result_type   upcoming_dates[$];
   int                fail_count;
   int                seen_count;

   function automatic bit leap_year(input int unsigned y);
      if (y % 100 == 0) begin
         return (y % 400) == 0;
      end
      return (y % 4) == 0;
   endfunction

   function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
      if (m inside {MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV}) begin
         return 30;
      end else if (m == MONTH_FEB) begin
         return leap_year(y) ? 29 : 28;
      end
      return 31;
   endfunction

   // days since the epoch Monday, counting the date itself, mod 7
   function automatic logic [WDAY_W-1:0] weekday_for(input date_type d);
      int unsigned acc;
      acc = 0;
      for (int unsigned y = EPOCH_YEAR; y < d.year; y++) begin
         acc = (acc + (leap_year(y) ? 2 : 1)) % 7;
      end
      for (int unsigned m = MONTH_JAN; m < d.month; m++) begin
         acc = (acc + days_in_month(m, d.year)) % 7;
      end
      return WDAY_W'((acc + d.day) % 7);
   endfunction

   task automatic walk_one_day(input logic restart, output date_result_type res);
      bit give;
      bit wrapped;
      give    = 1'b0;
      wrapped = 1'b0;
      if (restart) begin
         cur_date = start_date;
         cur_wday = weekday_for(cur_date);
         if (stop_date < cur_date) begin
            phase = WALK_DONE;
         end else begin
            phase = WALK_RUN;
            give  = 1'b1;
         end
      end else if (phase == WALK_RUN) begin
         if (cur_date == stop_date) begin
            phase = WALK_DONE;
         end else begin
            if (cur_date.day >= days_in_month(cur_date.month, cur_date.year)) begin
               cur_date.day = DAY_FIRST;
               if (cur_date.month >= MONTH_DEC) begin
                  cur_date.month = MONTH_JAN;
                  wrapped        = (cur_date.year == YEAR_MAX);
                  cur_date.year  = cur_date.year + 1'b1;
               end else begin
                  cur_date.month = cur_date.month + 1'b1;
               end
            end else begin
               cur_date.day = cur_date.day + 1'b1;
            end
            cur_wday = (cur_wday == WDAY_SATURDAY) ? WDAY_SUNDAY : cur_wday + 1'b1;
            if (wrapped || cur_date > stop_date) begin
               phase = WALK_DONE;
            end else begin
               give = 1'b1;
            end
         end
      end
      res = '0;
      if (give) begin
         res.valid_res = 1'b1;
         res.day       = cur_date.day;
         res.month     = cur_date.month;
         res.year      = cur_date.year;
         res.weekday   = cur_wday;
         res.last      = (cur_date == stop_date);
      end
   endtask

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         fail_count++;
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : monitor
      date_result_type want;
      if (reset) begin
         start_date = '{year: EPOCH_YEAR, month: MONTH_JAN, day: DAY_FIRST};
         stop_date  = start_date;
         cur_date   = start_date;
         cur_wday   = WDAY_MONDAY;
         phase      = WALK_IDLE;
         upcoming_dates.delete();
         fail_count = 0;
         seen_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FIRST_DAY:   start_date.day   = csr_wdata[DAY_W-1:0];
               CSR_FIRST_MONTH: start_date.month = csr_wdata[MONTH_W-1:0];
               CSR_FIRST_YEAR:  start_date.year  = csr_wdata;
               CSR_FINAL_DAY:   stop_date.day    = csr_wdata[DAY_W-1:0];
               CSR_FINAL_MONTH: stop_date.month  = csr_wdata[MONTH_W-1:0];
               CSR_FINAL_YEAR:  stop_date.year   = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            seen_count++;
            if (upcoming_dates.size() == 0) begin
               fail_count++;
               $display("%0t: result with nothing expected: valid_res %0d %0d-%0d-%0d wd %0d",
                        $time, rsp_valid_res, rsp_date_year, rsp_date_month, rsp_date_day,
                        rsp_weekday);
            end else begin
               want = upcoming_dates.pop_front();
               check_field("valid_res", want.valid_res, rsp_valid_res);
               check_field("date_day", want.day, rsp_date_day);
               check_field("date_month", want.month, rsp_date_month);
               check_field("date_year", want.year, rsp_date_year);
               check_field("weekday", want.weekday, rsp_weekday);
               check_field("last", want.last, rsp_last);
            end
         end
         if (req_valid && !req_stall) begin
            walk_one_day(req_restart, want);
            upcoming_dates.push_back(want);
         end
      end
      mismatches  <= fail_count;
      outstanding <= upcoming_dates.size();
      checked     <= seen_count;
   end

endmodule

@@ tb/calendar_date_sequencer_test.sv @@
// Top of the calendar date sequencer testbench: clock, reset, register writes, date-range
// stimulus with bursty requests and a stalling receiver, watchdog and verdict.
// Depends on cds_pkg, calendar_date_sequencer and date_walk_checker.
`timescale 1ns / 1ps
module calendar_date_sequencer_test;
   import cds_pkg::*;

   localparam int ITEM_TARGET = 550;
   localparam int QUIET_LIMIT = 60000;
   localparam int TAIL_CYCLES = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 3'd7;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_HEAVY} stall_mode_type;
   typedef enum {SHAPE_SAME_MONTH, SHAPE_NEXT_MONTH, SHAPE_NEW_YEAR, SHAPE_ANY, SHAPE_BACKWARD}
      range_shape_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic                   req_restart;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic                   rsp_valid_res;
   logic [DAY_W-1:0]       rsp_date_day;
   logic [MONTH_W-1:0]     rsp_date_month;
   logic [YEAR_W-1:0]      rsp_date_year;
   logic [WDAY_W-1:0]      rsp_weekday;
   logic                   rsp_last;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [YEAR_W-1:0]      csr_wdata;

   int mismatches;
   int outstanding;
   int checked;
   int sent_items;
   int restarts;
   int ranges;
   int burst_left;
   bit steady;

   calendar_date_sequencer dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_restart(req_restart),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_valid_res(rsp_valid_res),
      .rsp_date_day(rsp_date_day), .rsp_date_month(rsp_date_month),
      .rsp_date_year(rsp_date_year), .rsp_weekday(rsp_weekday), .rsp_last(rsp_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   date_walk_checker date_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_restart(req_restart),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_valid_res(rsp_valid_res),
      .rsp_date_day(rsp_date_day), .rsp_date_month(rsp_date_month),
      .rsp_date_year(rsp_date_year), .rsp_weekday(rsp_weekday), .rsp_last(rsp_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .mismatches(mismatches), .outstanding(outstanding), .checked(checked)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin : receiver
      stall_mode_type mode;
      int             left;
      mode = STALL_NONE;
      left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (left == 0) begin
            mode = stall_mode_type'($urandom_range(0, 3));
            left = $urandom_range(20, 200);
         end
         left--;
         case (mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HALF:  rsp_stall <= ($urandom_range(0, 1) == 0);
            default:     rsp_stall <= ($urandom_range(0, 15) != 0);
         endcase
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("%0t: no transfer for %0d cycles", $time, quiet);
      $display("FAIL");
      $finish;
   end

   function automatic date_type on_day(input int unsigned y, input int unsigned m,
                                       input int unsigned d);
      return '{year: YEAR_W'(y), month: MONTH_W'(m), day: DAY_W'(d)};
   endfunction

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [YEAR_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // junk in the upper data bits must be dropped for the narrow registers
   task automatic load_dates(input date_type first_date, input date_type final_date);
      logic [YEAR_W-1:0] pad;
      pad = ($urandom_range(0, 1) == 1) ? YEAR_W'($urandom()) : '0;
      if ($urandom_range(0, 5) == 0) begin
         write_csr(CSR_UNUSED, YEAR_W'($urandom()));
      end
      write_csr(CSR_FIRST_DAY, {pad[YEAR_W-1:DAY_W], first_date.day});
      write_csr(CSR_FIRST_MONTH, {pad[YEAR_W-1:MONTH_W], first_date.month});
      write_csr(CSR_FIRST_YEAR, first_date.year);
      write_csr(CSR_FINAL_DAY, {pad[YEAR_W-1:DAY_W], final_date.day});
      write_csr(CSR_FINAL_MONTH, {pad[YEAR_W-1:MONTH_W], final_date.month});
      write_csr(CSR_FINAL_YEAR, final_date.year);
      csr_valid <= 1'b0;
      ranges++;
   endtask

   task automatic send_item(input logic restart);
      int gap;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 16);
         gap = steady ? 0 : $urandom_range(0, 5);
         if (gap > 0) begin
            req_valid   <= 1'b0;
            req_restart <= 1'($urandom_range(0, 1));
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_restart <= restart;
      sent_items++;
      if (restart) begin
         restarts++;
      end
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // drop valid and hold until every transfer has its result
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (outstanding == 0);
      @(posedge clock);
   endtask

   task automatic run_directed(input date_type first_date, input date_type final_date,
                               input int advances);
      load_dates(first_date, final_date);
      send_item(1'b1);
      repeat (advances) send_item(1'b0);
      settle();
   endtask

   task automatic run_random_range();
      date_type        a;
      date_type        b;
      range_shape_type shape;
      int              r;
      int              n;
      r = $urandom_range(0, 99);
      if (r < 4) begin
         a.year = YEAR_W'($urandom_range(2200, 16383));
      end else if (r < 10) begin
         a.year = YEAR_W'($urandom_range(0, 1922));
      end else begin
         a.year = YEAR_W'($urandom_range(1923, 2130));
      end
      a.month = ($urandom_range(0, 9) == 0) ? MONTH_W'($urandom_range(0, 15))
                                            : MONTH_W'($urandom_range(1, 12));
      a.day   = ($urandom_range(0, 9) == 0) ? DAY_W'($urandom_range(0, 31))
                                            : DAY_W'($urandom_range(1, 28));
      shape = range_shape_type'($urandom_range(0, 4));
      b = a;
      case (shape)
         SHAPE_SAME_MONTH: b.day = DAY_W'($urandom_range(a.day, 31));
         SHAPE_NEXT_MONTH: begin
            if (a.month >= MONTH_DEC) begin
               b.year  = a.year + 1'b1;
               b.month = MONTH_JAN;
            end else begin
               b.month = a.month + 1'b1;
            end
            b.day = DAY_W'($urandom_range(1, 31));
         end
         SHAPE_NEW_YEAR: begin
            a.month = MONTH_DEC;
            a.day   = DAY_W'($urandom_range(20, 31));
            b.year  = a.year + 1'b1;
            b.month = MONTH_JAN;
            b.day   = DAY_W'($urandom_range(1, 15));
         end
         SHAPE_ANY: begin
            b.year  = a.year + YEAR_W'($urandom_range(0, 1));
            b.month = MONTH_W'($urandom_range(0, 15));
            b.day   = DAY_W'($urandom_range(0, 31));
         end
         default: b.year = a.year - 1'b1;
      endcase
      steady = ($urandom_range(0, 3) == 0);
      n = $urandom_range(3, 45);
      load_dates(a, b);
      if ($urandom_range(0, 19) == 0) begin
         send_item(1'b0);
      end
      send_item(1'b1);
      repeat (n - 1) send_item($urandom_range(0, 24) == 0);
      settle();
   endtask

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_restart <= 1'b0;
      csr_valid   <= 1'b0;
      csr_index   <= CSR_FIRST_DAY;
      csr_wdata   <= '0;
      sent_items = 0;
      restarts   = 0;
      ranges     = 0;
      burst_left = 0;
      steady     = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // idle advance, restart on the reset dates, then advances once finished
      send_item(1'b0);
      send_item(1'b1);
      send_item(1'b0);
      send_item(1'b0);
      settle();
      run_directed(on_day(2000, 2, 27), on_day(2000, 3, 1), 4);
      run_directed(on_day(1900, 2, 28), on_day(1900, 3, 1), 2);
      run_directed(on_day(2024, 5, 10), on_day(2024, 5, 9), 1);
      run_directed(on_day(0, 15, 31), on_day(1, 1, 2), 2);
      run_directed(on_day(2001, 2, 27), on_day(2001, 2, 30), 2);
      run_directed(on_day(1923, 0, 0), on_day(1923, 1, 1), 1);
      run_directed(on_day(YEAR_MAX, 12, 30), on_day(YEAR_MAX, 15, 31), 2);

      while (sent_items < ITEM_TARGET) begin
         run_random_range();
      end

      req_valid <= 1'b0;
      wait (outstanding == 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Sent %0d requests (%0d restarts) over %0d date ranges, %0d results compared.",
               sent_items, restarts, ranges, checked);
      $display("Ranges took in leap and century Februaries, year ends, odd days and months.");
      if (mismatches == 0 && outstanding == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
